### hdl/mtk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtk_pkg
// Shared types, key codes and character lookups for the multi-tap keypad
// entry block.
// ----------------------------------------------------------------------------
package mtk_pkg;

    localparam int unsigned CharW    = 7;
    localparam int unsigned TapW     = 3;
    localparam int unsigned IdleW    = 16;
    localparam int unsigned TimeoutW = 16;
    localparam int unsigned KeyIdxW  = 4;

    localparam logic [TimeoutW-1:0] TIMEOUT_RESET = 16'd500;
    localparam logic [IdleW-1:0]    IDLE_MAX      = '1;

    // key positions on the 4x4 layout
    localparam logic [KeyIdxW-1:0] KEY_STAR = 4'd12;
    localparam logic [KeyIdxW-1:0] KEY_HASH = 4'd14;

    localparam logic [CharW-1:0] CHAR_NONE  = 7'h00;
    localparam logic [CharW-1:0] CHAR_HASH  = 7'h23;
    localparam logic [CharW-1:0] CHAR_STAR  = 7'h2A;
    localparam logic [CharW-1:0] CHAR_SEVEN = 7'h37;

    // what the block holds between polls
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_LETTER,
        KIND_HASH,
        KIND_STASH
    } kind_t;

    typedef enum logic [1:0] {
        CLS_STAR,
        CLS_HASH,
        CLS_DIRECT,
        CLS_TAP
    } key_cls_t;

    typedef struct packed {
        logic               key_pressed;
        logic [KeyIdxW-1:0] key_index;
    } poll_t;

    typedef struct packed {
        logic [CharW-1:0] out_char;
        logic             mode_toggle;
        logic [CharW-1:0] preview_char;
    } result_t;

    typedef struct packed {
        kind_t            kind;
        logic [CharW-1:0] ch;
        logic [TapW-1:0]  tap;
        logic [IdleW-1:0] idle;
    } entry_state_t;

    function automatic logic [CharW-1:0] key_char(input logic [KeyIdxW-1:0] idx);
        logic [CharW-1:0] c;
        unique case (idx)
            4'd0:    c = 7'h31; // 1
            4'd1:    c = 7'h32; // 2
            4'd2:    c = 7'h33; // 3
            4'd3:    c = 7'h41; // A
            4'd4:    c = 7'h34; // 4
            4'd5:    c = 7'h35; // 5
            4'd6:    c = 7'h36; // 6
            4'd7:    c = 7'h42; // B
            4'd8:    c = 7'h37; // 7
            4'd9:    c = 7'h38; // 8
            4'd10:   c = 7'h39; // 9
            4'd11:   c = 7'h43; // C
            4'd12:   c = CHAR_STAR;
            4'd13:   c = 7'h30; // 0
            4'd14:   c = CHAR_HASH;
            default: c = 7'h44; // D
        endcase
        return c;
    endfunction

    function automatic key_cls_t key_class(input logic [KeyIdxW-1:0] idx);
        key_cls_t k;
        unique case (idx)
            KEY_STAR:                             k = CLS_STAR;
            KEY_HASH:                             k = CLS_HASH;
            4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd6,
            4'd8:                                 k = CLS_TAP;
            default:                              k = CLS_DIRECT;
        endcase
        return k;
    endfunction

    // letter shown for multi-tap key ch after tap presses
    function automatic logic [CharW-1:0] tap_letter(input logic [CharW-1:0] ch,
                                                    input logic [TapW-1:0]  tap);
        logic [CharW-1:0] c;
        c = CHAR_NONE;
        unique case (ch)
            7'h31: unique case (tap)
                3'd1: c = 7'h45; 3'd2: c = 7'h46; 3'd3: c = 7'h47; 3'd4: c = 7'h31;
                default: c = CHAR_NONE;
            endcase
            7'h32: unique case (tap)
                3'd1: c = 7'h48; 3'd2: c = 7'h49; 3'd3: c = 7'h4A; 3'd4: c = 7'h32;
                default: c = CHAR_NONE;
            endcase
            7'h33: unique case (tap)
                3'd1: c = 7'h4B; 3'd2: c = 7'h4C; 3'd3: c = 7'h4D; 3'd4: c = 7'h33;
                default: c = CHAR_NONE;
            endcase
            7'h34: unique case (tap)
                3'd1: c = 7'h4E; 3'd2: c = 7'h4F; 3'd3: c = 7'h50; 3'd4: c = 7'h34;
                default: c = CHAR_NONE;
            endcase
            7'h35: unique case (tap)
                3'd1: c = 7'h51; 3'd2: c = 7'h52; 3'd3: c = 7'h53; 3'd4: c = 7'h35;
                default: c = CHAR_NONE;
            endcase
            7'h36: unique case (tap)
                3'd1: c = 7'h54; 3'd2: c = 7'h55; 3'd3: c = 7'h56; 3'd4: c = 7'h36;
                default: c = CHAR_NONE;
            endcase
            7'h37: unique case (tap)
                3'd1: c = 7'h57; 3'd2: c = 7'h58; 3'd3: c = 7'h59; 3'd4: c = 7'h5A;
                3'd5: c = 7'h37;
                default: c = CHAR_NONE;
            endcase
            default: c = CHAR_NONE;
        endcase
        return c;
    endfunction

endpackage

### hdl/mtk_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtk_step
// One poll of multi-tap entry: next held state and the result of the poll.
// ----------------------------------------------------------------------------
module mtk_step (
    input  mtk_pkg::poll_t                       poll,
    input  mtk_pkg::entry_state_t                st,
    input  logic [mtk_pkg::TimeoutW-1:0]         timeout,
    output mtk_pkg::entry_state_t                st_next,
    output mtk_pkg::result_t                     res
);

    logic [mtk_pkg::CharW-1:0] k;
    mtk_pkg::key_cls_t         cls;
    logic                      active;
    logic [mtk_pkg::CharW-1:0] cur_letter;
    logic [mtk_pkg::TapW-1:0]  group_len;
    logic [mtk_pkg::IdleW-1:0] idle_inc;
    logic [mtk_pkg::CharW-1:0] c;
    logic                      tog;

    assign k          = mtk_pkg::key_char(poll.key_index);
    assign cls        = mtk_pkg::key_class(poll.key_index);
    // a stash counts as an active letter that confirms to nothing
    assign active     = (st.kind == mtk_pkg::KIND_LETTER) || (st.kind == mtk_pkg::KIND_STASH);
    assign cur_letter = (st.kind == mtk_pkg::KIND_LETTER) ? mtk_pkg::tap_letter(st.ch, st.tap)
                                                          : mtk_pkg::CHAR_NONE;
    assign group_len  = (st.ch == mtk_pkg::CHAR_SEVEN) ? 3'd5 : 3'd4;
    assign idle_inc   = (st.idle == mtk_pkg::IDLE_MAX) ? st.idle : st.idle + 1'b1;

    always_comb
    begin
        st_next = st;
        c       = mtk_pkg::CHAR_NONE;
        tog     = 1'b0;
        if (poll.key_pressed)
        begin
            st_next.idle = '0;
            unique case (cls)
                mtk_pkg::CLS_STAR:
                begin
                    tog = 1'b1;
                    if (active)
                    begin
                        c            = cur_letter;
                        st_next.kind = mtk_pkg::KIND_NONE;
                    end
                end
                mtk_pkg::CLS_HASH:
                begin
                    if (active)
                    begin
                        c            = cur_letter;
                        st_next.kind = mtk_pkg::KIND_HASH;
                        st_next.ch   = mtk_pkg::CHAR_HASH;
                        st_next.tap  = 3'd1;
                    end
                    else
                    begin
                        c = mtk_pkg::CHAR_HASH;
                    end
                end
                mtk_pkg::CLS_DIRECT:
                begin
                    c = k;
                    if (st.kind == mtk_pkg::KIND_LETTER)
                    begin
                        // letter goes out, direct key waits behind it
                        c            = cur_letter;
                        st_next.kind = mtk_pkg::KIND_STASH;
                        st_next.ch   = k;
                    end
                    else if (st.kind == mtk_pkg::KIND_STASH)
                    begin
                        st_next.kind = mtk_pkg::KIND_NONE;
                    end
                end
                default:
                begin
                    priority if (st.kind == mtk_pkg::KIND_STASH)
                    begin
                        c            = st.ch;
                        st_next.kind = mtk_pkg::KIND_LETTER;
                        st_next.ch   = k;
                        st_next.tap  = 3'd1;
                    end
                    else if (st.kind == mtk_pkg::KIND_LETTER && st.ch == k)
                    begin
                        st_next.tap = (st.tap == group_len) ? 3'd1 : st.tap + 1'b1;
                    end
                    else
                    begin
                        // deferred hash is dropped here
                        c            = cur_letter;
                        st_next.kind = mtk_pkg::KIND_LETTER;
                        st_next.ch   = k;
                        st_next.tap  = 3'd1;
                    end
                end
            endcase
        end
        else
        begin
            if (active)
            begin
                st_next.idle = idle_inc;
                if (idle_inc >= timeout)
                begin
                    c            = cur_letter;
                    st_next.kind = mtk_pkg::KIND_NONE;
                    st_next.idle = '0;
                end
            end
            else if (st.kind == mtk_pkg::KIND_HASH)
            begin
                c            = mtk_pkg::CHAR_HASH;
                st_next.kind = mtk_pkg::KIND_NONE;
                st_next.idle = '0;
            end
        end
    end

    always_comb
    begin
        res.out_char     = c;
        res.mode_toggle  = tog;
        res.preview_char = (st_next.kind == mtk_pkg::KIND_LETTER)
                         ? mtk_pkg::tap_letter(st_next.ch, st_next.tap)
                         : mtk_pkg::CHAR_NONE;
    end

endmodule

### hdl/multi_tap_keypad_entry_top.sv
`timescale 1ns / 1ps
// the result of an accepted poll request is registered in the output register
// throughput: one poll per cycle; a poll is taken whenever the output register is empty
//   or is being drained in the same cycle
// reset (rst_n low, asynchronous): nothing pending, idle count zero, timeout 500 polls,
//   output register empty
// ----------------------------------------------------------------------------
// multi_tap_keypad_entry_top
// Multi-tap text entry for a 4x4 keypad: one poll request in, one result out,
// with a single configuration register for the idle timeout.
// ----------------------------------------------------------------------------
module multi_tap_keypad_entry_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // poll requests
    input  logic                          poll_valid,
    output logic                          poll_ready,
    input  mtk_pkg::poll_t                poll,
    // results
    output logic                          result_valid,
    input  logic                          result_ready,
    output mtk_pkg::result_t              result,
    // timeout register write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mtk_pkg::TimeoutW-1:0]  cfg_data
);

    // idle timeout register
    logic [mtk_pkg::TimeoutW-1:0] timeout_reg;

    // held entry state: pending letter, stash, deferred hash, idle count
    mtk_pkg::entry_state_t st_reg;
    mtk_pkg::entry_state_t st_next;

    // output register
    logic             result_valid_reg;
    mtk_pkg::result_t result_reg;
    mtk_pkg::result_t result_next;

    logic poll_accept;

    // writes are always taken
    assign cfg_ready = 1'b1;

    // output register frees up in the same cycle it is drained
    assign poll_ready  = !result_valid_reg || result_ready;
    assign poll_accept = poll_valid && poll_ready;

    mtk_step u_step (
        .poll    (poll),
        .st      (st_reg),
        .timeout (timeout_reg),
        .st_next (st_next),
        .res     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= mtk_pkg::TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            timeout_reg <= cfg_data;
        end
    end

    // state advances only on an accepted poll
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.kind <= mtk_pkg::KIND_NONE;
            st_reg.ch   <= mtk_pkg::CHAR_NONE;
            st_reg.tap  <= '0;
            st_reg.idle <= '0;
        end
        else if (poll_accept)
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (poll_accept)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (poll_accept)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // preview shows a letter exactly when a multi-tap letter is held
    a_preview_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |->
            ((result_reg.preview_char != mtk_pkg::CHAR_NONE)
             == (st_reg.kind == mtk_pkg::KIND_LETTER)))
        else $error("preview does not match held state");

    // star request always yields a mode toggle pulse
    a_star_toggles: assert property (@(posedge clk) disable iff (!rst_n)
        (poll_accept && poll.key_pressed && poll.key_index == mtk_pkg::KEY_STAR)
            |=> (result_valid_reg && result_reg.mode_toggle))
        else $error("star request without mode toggle");

    // idle count only runs while a letter or stash is held
    a_idle_only_when_active: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.kind == mtk_pkg::KIND_NONE || st_reg.kind == mtk_pkg::KIND_HASH)
            |-> (st_reg.idle == '0))
        else $error("idle count running with nothing held");

endmodule

### tb/mtk_entry_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtk_entry_checker
// Watches the poll, result and timeout channels of the keypad entry block,
// keeps its own copy of the multi-tap state, and compares every result
// against the character it works out for the matching poll.
// ----------------------------------------------------------------------------
module mtk_entry_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          poll_valid,
    input  logic                          poll_ready,
    input  mtk_pkg::poll_t                poll,
    input  logic                          result_valid,
    input  logic                          result_ready,
    input  mtk_pkg::result_t              result,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [mtk_pkg::TimeoutW-1:0]  cfg_data,
    output int                            fails,
    output int                            outstanding,
    output int                            checked,
    output int                            confirmed,
    output int                            toggles
);

    localparam logic [7:0] CH_STAR    = "*";
    localparam logic [7:0] CH_HASH    = "#";
    localparam logic [7:0] STASH_TAPS = 8'd255;

    // mirrored entry state
    logic [7:0]  held_key    = 8'd0;
    logic [7:0]  taps        = 8'd0;
    logic [15:0] quiet_polls = 16'd0;
    logic [15:0] quiet_limit = mtk_pkg::TIMEOUT_RESET;

    mtk_pkg::result_t awaited[$];

    int err_cnt     = 0;
    int queue_depth = 0;
    int result_cnt  = 0;
    int char_cnt    = 0;
    int toggle_cnt  = 0;

    assign fails       = err_cnt;
    assign outstanding = queue_depth;
    assign checked     = result_cnt;
    assign confirmed   = char_cnt;
    assign toggles     = toggle_cnt;

    function automatic logic [7:0] key_ascii(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "1";
            4'd1:    c = "2";
            4'd2:    c = "3";
            4'd3:    c = "A";
            4'd4:    c = "4";
            4'd5:    c = "5";
            4'd6:    c = "6";
            4'd7:    c = "B";
            4'd8:    c = "7";
            4'd9:    c = "8";
            4'd10:   c = "9";
            4'd11:   c = "C";
            4'd12:   c = CH_STAR;
            4'd13:   c = "0";
            4'd14:   c = CH_HASH;
            default: c = "D";
        endcase
        return c;
    endfunction

    // letters plus the digit itself; zero for keys without a letter group
    function automatic int unsigned group_len(input logic [7:0] k);
        if (k >= "1" && k <= "6")
            return 4;
        if (k == "7")
            return 5;
        return 0;
    endfunction

    function automatic logic [7:0] shown_letter();
        int unsigned len;
        int unsigned pos;
        len = group_len(held_key);
        if (held_key == 8'd0 || taps == 8'd0 || len == 0)
            return 8'd0;
        pos = (taps - 1) % len;
        if (pos == len - 1)
            return held_key;
        // groups run E-G, H-J, ... W-Z in key order
        return 8'("E" + 3 * (held_key - "1") + pos);
    endfunction

    function automatic logic [7:0] take_letter();
        logic [7:0] c;
        c           = shown_letter();
        held_key    = 8'd0;
        taps        = 8'd0;
        quiet_polls = 16'd0;
        return c;
    endfunction

    // a stash counts as live here, a deferred hash does not
    function automatic bit letter_live();
        return held_key != 8'd0 && taps != 8'd0 && held_key != CH_HASH;
    endfunction

    function automatic logic [7:0] on_key(input logic [7:0] k, output bit toggle);
        logic [7:0] c;
        int unsigned len;
        c           = 8'd0;
        toggle      = 1'b0;
        quiet_polls = 16'd0;
        len         = group_len(k);
        if (k == CH_STAR)
        begin
            if (letter_live())
                c = take_letter();
            toggle = 1'b1;
            return c;
        end
        if (k == CH_HASH)
        begin
            if (letter_live())
            begin
                c        = take_letter();
                held_key = CH_HASH;
                taps     = 8'd1;
                return c;
            end
            return CH_HASH;
        end
        if (len == 0)
        begin
            if (letter_live())
                c = take_letter();
            if (c != 8'd0)
            begin
                held_key = k;
                taps     = STASH_TAPS;
                return c;
            end
            return k;
        end
        // multi-tap key from here on
        if (held_key != 8'd0 && taps == STASH_TAPS)
        begin
            c        = held_key;
            held_key = k;
            taps     = 8'd1;
            return c;
        end
        if (k == held_key)
        begin
            taps = taps + 8'd1;
            if (taps > len)
                taps = 8'd1;
            return 8'd0;
        end
        if (held_key != 8'd0 && taps != 8'd0)
            c = take_letter();
        held_key = k;
        taps     = 8'd1;
        return c;
    endfunction

    function automatic logic [7:0] on_idle();
        if (letter_live())
        begin
            if (quiet_polls != 16'hFFFF)
                quiet_polls = quiet_polls + 16'd1;
            if (quiet_polls >= quiet_limit)
                return take_letter();
        end
        if (held_key == CH_HASH)
        begin
            held_key    = 8'd0;
            taps        = 8'd0;
            quiet_polls = 16'd0;
            return CH_HASH;
        end
        return 8'd0;
    endfunction

    function automatic mtk_pkg::result_t entry_step(input mtk_pkg::poll_t p);
        mtk_pkg::result_t r;
        logic [7:0]       c;
        logic [7:0]       shown;
        bit               toggle;
        toggle = 1'b0;
        if (p.key_pressed)
            c = on_key(key_ascii(p.key_index), toggle);
        else
            c = on_idle();
        shown          = shown_letter();
        r.out_char     = c[6:0];
        r.mode_toggle  = toggle;
        r.preview_char = shown[6:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [6:0] want,
                                        input logic [6:0] got);
        if (got !== want)
        begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mtk_pkg::result_t want;
        if (!rst_n)
        begin
            held_key    = 8'd0;
            taps        = 8'd0;
            quiet_polls = 16'd0;
            quiet_limit = mtk_pkg::TIMEOUT_RESET;
            awaited.delete();
            queue_depth = 0;
        end
        else
        begin
            // the result leaving now belongs to an earlier poll
            if (result_valid && result_ready)
            begin
                if (awaited.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, result);
                end
                else
                begin
                    want = awaited.pop_front();
                    check_field("out_char", want.out_char, result.out_char);
                    check_field("mode_toggle", 7'(want.mode_toggle), 7'(result.mode_toggle));
                    check_field("preview_char", want.preview_char, result.preview_char);
                    result_cnt++;
                    if (want.out_char != 7'd0)
                        char_cnt++;
                    if (want.mode_toggle)
                        toggle_cnt++;
                end
            end
            if (cfg_valid && cfg_ready)
                quiet_limit = cfg_data;
            if (poll_valid && poll_ready)
                awaited.push_back(entry_step(poll));
            queue_depth = awaited.size();
        end
    end

endmodule

### tb/tb_multi_tap_keypad_entry_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_tap_keypad_entry_top
// Drives poll requests and timeout writes into the keypad entry block,
// with random gaps and stalls on both channels; a checker beside the block
// predicts and compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_multi_tap_keypad_entry_top;

    localparam int CYCLE_LIMIT = 20_000;

    // key positions on the 4x4 layout (star and hash come from the package)
    localparam logic [3:0] KEY_1 = 4'd0,  KEY_2 = 4'd1,  KEY_3 = 4'd2,  KEY_A = 4'd3;
    localparam logic [3:0] KEY_4 = 4'd4,  KEY_5 = 4'd5,  KEY_6 = 4'd6,  KEY_B = 4'd7;
    localparam logic [3:0] KEY_7 = 4'd8,  KEY_8 = 4'd9,  KEY_9 = 4'd10, KEY_C = 4'd11;
    localparam logic [3:0] KEY_0 = 4'd13, KEY_D = 4'd15;

    logic                         clk;
    logic                         rst_n;
    logic                         poll_valid;
    logic                         poll_ready;
    mtk_pkg::poll_t               poll;
    logic                         result_valid;
    logic                         result_ready;
    mtk_pkg::result_t             result;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [mtk_pkg::TimeoutW-1:0] cfg_data;

    int fails;
    int outstanding;
    int checked;
    int confirmed;
    int toggles;

    // knobs shared by the stimulus processes
    int          gap_pct     = 0;     // chance per cycle that the sender idles
    int          stall_pct   = 0;     // chance per cycle that the receiver stalls
    int          hold_cycles = 0;     // long receiver hold-off still to run
    int          sent        = 0;     // poll requests accepted so far
    int unsigned cur_timeout = 500;   // timeout the block currently holds

    multi_tap_keypad_entry_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .poll_valid   (poll_valid),
        .poll_ready   (poll_ready),
        .poll         (poll),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    mtk_entry_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .poll_valid   (poll_valid),
        .poll_ready   (poll_ready),
        .poll         (poll),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fails        (fails),
        .outstanding  (outstanding),
        .checked      (checked),
        .confirmed    (confirmed),
        .toggles      (toggles)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver: random stalls, or a long hold-off when one is requested
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                result_ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                result_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // hard stop in case a handshake never completes
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("no progress after %0d cycles, %0d results still due", cycles, outstanding);
        $display("tb_multi_tap_keypad_entry_top failed");
        $finish;
    end

    // one poll request; entered and left at a falling edge, valid stays up
    // between back-to-back requests
    task automatic send_poll(input logic pressed, input logic [3:0] idx);
        mtk_pkg::poll_t p;
        p.key_pressed = pressed;
        p.key_index   = idx;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            poll_valid <= 1'b0;
            @(negedge clk);
        end
        poll_valid <= 1'b1;
        poll       <= p;
        do
            @(posedge clk);
        while (!poll_ready);
        sent++;
        @(negedge clk);
    endtask

    task automatic press(input logic [3:0] idx);
        send_poll(1'b1, idx);
    endtask

    // key_index carries junk on idle polls, the block must ignore it
    task automatic idle_poll();
        send_poll(1'b0, 4'($urandom_range(0, 15)));
    endtask

    // stop sending and wait until every result has come back
    task automatic drain();
        poll_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // timeout writes only ever happen with the block drained
    task automatic write_timeout(input int unsigned value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= 16'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid   <= 1'b0;
        cur_timeout = value;
    endtask

    function automatic logic [3:0] tap_key();
        logic [3:0] k;
        case ($urandom_range(0, 6))
            0:       k = KEY_1;
            1:       k = KEY_2;
            2:       k = KEY_3;
            3:       k = KEY_4;
            4:       k = KEY_5;
            5:       k = KEY_6;
            default: k = KEY_7;
        endcase
        return k;
    endfunction

    function automatic logic [3:0] direct_key();
        logic [3:0] k;
        case ($urandom_range(0, 6))
            0:       k = KEY_A;
            1:       k = KEY_B;
            2:       k = KEY_C;
            3:       k = KEY_D;
            4:       k = KEY_0;
            5:       k = KEY_8;
            default: k = KEY_9;
        endcase
        return k;
    endfunction

    // mostly typing-like bursts: repeated taps on one key, confirmations,
    // idle runs sized around a timeout below 10 (else up to 4 polls), plus some fully random keys
    task automatic random_burst();
        int unsigned pick;
        int unsigned n;
        int unsigned run_max;
        logic [3:0]  k;
        pick    = $urandom_range(0, 99);
        run_max = (cur_timeout < 10) ? cur_timeout + 2 : 4;
        if (pick < 40)
        begin
            k = tap_key();
            n = $urandom_range(1, 6);
            repeat (n) press(k);
        end
        else if (pick < 52)
        begin
            press(direct_key());
        end
        else if (pick < 60)
        begin
            press(mtk_pkg::KEY_STAR);
        end
        else if (pick < 70)
        begin
            press(mtk_pkg::KEY_HASH);
        end
        else if (pick < 90)
        begin
            n = $urandom_range(1, run_max);
            repeat (n) idle_poll();
        end
        else
        begin
            press(4'($urandom_range(0, 15)));
        end
    endtask

    task automatic random_run(input int count);
        int stop_at;
        stop_at = sent + count;
        while (sent < stop_at)
            random_burst();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        poll_valid = 1'b0;
        poll       = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ---- directed, reset timeout of 500, no idling ----
        repeat (5) press(KEY_2);       // H I J 2 and wrap back to H
        repeat (6) press(KEY_7);       // five-entry group W X Y Z 7, then wrap
        press(KEY_4);                  // different key confirms the pending W
        press(KEY_A);                  // direct key behind a letter: N out, A stashed
        press(KEY_5);                  // next multi-tap key releases the stash
        press(mtk_pkg::KEY_HASH);      // Q out, hash deferred
        press(mtk_pkg::KEY_STAR);      // toggle, hash stays deferred
        press(KEY_B);                  // direct key passes, hash stays deferred
        press(mtk_pkg::KEY_HASH);      // hash while deferred: hash out, still deferred
        idle_poll();                   // idle poll flushes the deferred hash
        press(KEY_6);
        press(KEY_C);                  // T out, C stashed
        press(mtk_pkg::KEY_STAR);      // star drops the stash
        press(KEY_1);
        press(KEY_D);                  // E out, D stashed
        press(KEY_D);                  // stash lost, new direct key out
        press(KEY_1);
        press(KEY_0);                  // E out, 0 stashed
        press(mtk_pkg::KEY_HASH);      // stash lost, hash deferred
        press(KEY_6);                  // multi-tap key drops the deferred hash
        idle_poll();                   // far below the timeout, nothing happens

        // ---- zero timeout, no idling ----
        write_timeout(0);
        press(KEY_2);
        idle_poll();                   // first idle poll confirms at once
        press(KEY_2);
        press(KEY_A);
        idle_poll();                   // stash cleared by the timeout
        press(KEY_1);
        press(mtk_pkg::KEY_HASH);
        idle_poll();
        random_run(60);

        // ---- timeout 1, sender idling ----
        write_timeout(1);
        gap_pct = 72;
        random_run(70);

        // ---- timeout 3, receiver stalling, with a long hold-off up front ----
        write_timeout(3);
        gap_pct     = 0;
        stall_pct   = 72;
        hold_cycles = 150;             // sender keeps offering, block backs up
        random_run(70);

        // ---- small random timeout, both sides idling ----
        write_timeout($urandom_range(2, 12));
        gap_pct   = 27;
        stall_pct = 27;
        random_run(35);
        drain();                       // sender waits for every result
        random_run(35);

        // ---- largest timeout, letter held through a run of idle polls ----
        write_timeout(65535);
        gap_pct   = 0;
        stall_pct = 0;
        press(KEY_3);
        repeat (8) idle_poll();        // far below the timeout, K stays pending
        press(mtk_pkg::KEY_STAR);      // star confirms K
        random_run(40);

        // ---- small random timeout, no idling ----
        write_timeout($urandom_range(1, 6));
        random_run(60);

        drain();
        repeat (20) @(negedge clk);    // room for any stray result

        $display("covered %0d poll requests over seven timeout settings incl. 0, 1, 65535",
                 sent);
        $display("%0d results checked, %0d characters confirmed, %0d mode toggles",
                 checked, confirmed, toggles);
        if (fails == 0)
            $display("tb_multi_tap_keypad_entry_top passed");
        else
            $display("tb_multi_tap_keypad_entry_top failed");
        $finish;
    end

endmodule
